@@ rtl/tlbfl_pkg.sv @@
`default_nettype none

package tlbfl_pkg;

    // Built depth of the buffer.
    localparam int ENTRIES    = 16;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W      = $clog2(ENTRIES + 1);

    localparam int PAGE_W     = 32;
    localparam int FRAME_W    = 32;
    localparam int POLICY_W   = 2;
    localparam int LIMIT_W    = 7;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_POLICY  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = CFG_IDX_W'(1);

    // Replacement policy codes.
    localparam logic [POLICY_W-1:0] POL_FIFO = POLICY_W'(0);
    localparam logic [POLICY_W-1:0] POL_LRU  = POLICY_W'(1);

    // Action chosen for an item during the search cycle.
    localparam int ACT_W = 3;
    localparam logic [ACT_W-1:0] ACT_NOP     = ACT_W'(0);
    localparam logic [ACT_W-1:0] ACT_HIT     = ACT_W'(1);
    localparam logic [ACT_W-1:0] ACT_FILL    = ACT_W'(2);
    localparam logic [ACT_W-1:0] ACT_REPLACE = ACT_W'(3);
    localparam logic [ACT_W-1:0] ACT_ERROR   = ACT_W'(4);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic find_en;
        logic commit_en;
    } tlbfl_cmd_t;

endpackage

`default_nettype wire

@@ rtl/tlb_fifo_lru_replacement.sv @@
`default_nettype none

// Fully associative translation buffer of 16 entries with FIFO or LRU
// replacement. Each input transaction is either a lookup (s_mode low), which
// returns the frame of the earliest-inserted entry whose page matches and
// marks that entry most recently used, or an insert (s_mode high), which
// fills a free entry while fewer entries are valid than the configured count
// and otherwise replaces the oldest (FIFO) or least recently used (LRU)
// entry, reporting the evicted page. With an unrecognized policy a full
// buffer drops the insert and raises m_policy_error. Every input transaction
// produces exactly one result transaction. An item has a search step and a
// commit step: the cycle it is accepted runs the parallel page compare and the
// victim or free-slot search into registers, and the commit step does the rank
// update and loads the output register. The commit waits while a previous
// result still sits unaccepted in the output register, so a stalled result
// channel holds the block after one further item. Register 0 is the
// replacement policy and register 1 the allowed entry count; the
// configuration channel is always ready, and writes to other indexes are
// ignored. Configuration should only be written while the block is idle.
module tlb_fifo_lru_replacement
    import tlbfl_pkg::*;
(
    input  wire                   aclk,
    input  wire                   aresetn,
    // Input transactions.
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire                   s_mode,
    input  wire  [PAGE_W-1:0]     s_page,
    input  wire  [FRAME_W-1:0]    s_frame,
    // Result transactions.
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic                  m_hit,
    output logic [FRAME_W-1:0]    m_found_frame,
    output logic                  m_evicted,
    output logic [PAGE_W-1:0]     m_evicted_page,
    output logic                  m_policy_error,
    // Configuration writes.
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire  [CFG_IDX_W-1:0]  cfg_index,
    input  wire  [CFG_DATA_W-1:0] cfg_data
);

    tlbfl_cmd_t cmd;
    logic       cfg_we;

    // Register writes go straight into registers, so the port never stalls.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // The controller sequences search and commit and owns the output valid.
    tlbfl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // The datapath holds the entries, ranks, configuration and result payload.
    tlbfl_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_mode         (s_mode),
        .s_page         (s_page),
        .s_frame        (s_frame),
        .m_hit          (m_hit),
        .m_found_frame  (m_found_frame),
        .m_evicted      (m_evicted),
        .m_evicted_page (m_evicted_page),
        .m_policy_error (m_policy_error)
    );

endmodule

`default_nettype wire

@@ rtl/tlbfl_ctrl.sv @@
`default_nettype none

module tlbfl_ctrl
    import tlbfl_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  wire        m_ready,
    output tlbfl_cmd_t cmd
);

    localparam int STATE_W = 1;
    localparam logic [STATE_W-1:0] ST_IDLE   = STATE_W'(0);
    localparam logic [STATE_W-1:0] ST_COMMIT = STATE_W'(1);

    logic [STATE_W-1:0] state_reg, state_next;
    logic               m_valid_reg, m_valid_next;
    logic               out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg;
        cmd.find_en   = 1'b0;
        cmd.commit_en = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.find_en = 1'b1;
                    state_next  = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                // Commit only once the output register can take the result.
                if (out_free) begin
                    cmd.commit_en = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tlbfl_dp.sv @@
`default_nettype none

module tlbfl_dp
    import tlbfl_pkg::*;
(
    input  wire                   aclk,
    input  wire                   aresetn,
    input  tlbfl_cmd_t            cmd,
    input  wire                   cfg_we,
    input  wire  [CFG_IDX_W-1:0]  cfg_index,
    input  wire  [CFG_DATA_W-1:0] cfg_data,
    input  wire                   s_mode,
    input  wire  [PAGE_W-1:0]     s_page,
    input  wire  [FRAME_W-1:0]    s_frame,
    output logic                  m_hit,
    output logic [FRAME_W-1:0]    m_found_frame,
    output logic                  m_evicted,
    output logic [PAGE_W-1:0]     m_evicted_page,
    output logic                  m_policy_error
);

    // Configuration.
    logic [POLICY_W-1:0] policy_reg;
    logic [LIMIT_W-1:0]  entries_reg;

    // Entry state.
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    idx_t                ins_rank_reg [ENTRIES];
    idx_t                ins_rank_next[ENTRIES];
    idx_t                use_rank_reg [ENTRIES];
    idx_t                use_rank_next[ENTRIES];
    cnt_t                count_reg, count_next;
    logic [PAGE_W-1:0]   page_mem [ENTRIES];
    logic [FRAME_W-1:0]  frame_mem[ENTRIES];

    // Item held between search and commit.
    logic [PAGE_W-1:0]   page_reg;
    logic [FRAME_W-1:0]  frame_reg;
    idx_t                sel_reg;
    logic [ACT_W-1:0]    act_reg;

    // Search results.
    logic [ENTRIES-1:0]  match;
    logic [ENTRIES-1:0]  oldest_match;
    idx_t                best_idx, free_idx, victim_idx;
    logic                any_match, free_found, victim_found;
    logic [LIMIT_W-1:0]  limit;
    logic                full;
    logic                policy_known;
    logic [ACT_W-1:0]    act_new;
    idx_t                sel_new;

    // Rank update helpers.
    idx_t                sel_ins, sel_use, newest;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = valid_reg[i] && (page_mem[i] == s_page);
        end
        // Among matches, the one with no older match is the earliest inserted.
        for (int i = 0; i < ENTRIES; i++) begin
            oldest_match[i] = match[i];
            for (int j = 0; j < ENTRIES; j++) begin
                if (match[j] && (ins_rank_reg[j] < ins_rank_reg[i])) begin
                    oldest_match[i] = 1'b0;
                end
            end
        end
        best_idx     = '0;
        any_match    = 1'b0;
        free_idx     = '0;
        free_found   = 1'b0;
        victim_idx   = '0;
        victim_found = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (oldest_match[i]) begin
                best_idx  = idx_t'(i);
                any_match = 1'b1;
            end
            if (!valid_reg[i]) begin
                free_idx   = idx_t'(i);
                free_found = 1'b1;
            end
            if (valid_reg[i] && (((policy_reg == POL_FIFO) && (ins_rank_reg[i] == '0)) ||
                                 ((policy_reg == POL_LRU) && (use_rank_reg[i] == '0)))) begin
                victim_idx   = idx_t'(i);
                victim_found = 1'b1;
            end
        end

        // Allowed count, clamped to the range one to the built depth.
        if (entries_reg > LIMIT_W'(ENTRIES)) begin
            limit = LIMIT_W'(ENTRIES);
        end else if (entries_reg == '0) begin
            limit = LIMIT_W'(1);
        end else begin
            limit = entries_reg;
        end
        full         = LIMIT_W'(count_reg) >= limit;
        policy_known = (policy_reg == POL_FIFO) || (policy_reg == POL_LRU);

        act_new = ACT_NOP;
        sel_new = '0;
        if (!s_mode) begin
            if (any_match) begin
                act_new = ACT_HIT;
                sel_new = best_idx;
            end
        end else if (!full) begin
            if (free_found) begin
                act_new = ACT_FILL;
                sel_new = free_idx;
            end
        end else if (policy_known) begin
            if (victim_found) begin
                act_new = ACT_REPLACE;
                sel_new = victim_idx;
            end
        end else begin
            act_new = ACT_ERROR;
        end
    end

    always_comb begin
        sel_ins    = ins_rank_reg[sel_reg];
        sel_use    = use_rank_reg[sel_reg];
        newest     = idx_t'(count_reg - cnt_t'(1));
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < ENTRIES; i++) begin
            ins_rank_next[i] = ins_rank_reg[i];
            use_rank_next[i] = use_rank_reg[i];
        end
        if (cmd.commit_en) begin
            case (act_reg)
                ACT_HIT: begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (valid_reg[i] && (use_rank_reg[i] > sel_use)) begin
                            use_rank_next[i] = use_rank_reg[i] - idx_t'(1);
                        end
                    end
                    use_rank_next[sel_reg] = newest;
                end
                ACT_FILL: begin
                    valid_next[sel_reg]    = 1'b1;
                    ins_rank_next[sel_reg] = count_reg[IDX_W-1:0];
                    use_rank_next[sel_reg] = count_reg[IDX_W-1:0];
                    count_next             = count_reg + cnt_t'(1);
                end
                ACT_REPLACE: begin
                    // Close the gaps left by the victim, then make it the newest.
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (valid_reg[i] && (idx_t'(i) != sel_reg)) begin
                            if (ins_rank_reg[i] > sel_ins) begin
                                ins_rank_next[i] = ins_rank_reg[i] - idx_t'(1);
                            end
                            if (use_rank_reg[i] > sel_use) begin
                                use_rank_next[i] = use_rank_reg[i] - idx_t'(1);
                            end
                        end
                    end
                    ins_rank_next[sel_reg] = newest;
                    use_rank_next[sel_reg] = newest;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg  <= POL_FIFO;
            entries_reg <= LIMIT_W'(16);
            valid_reg   <= '0;
            count_reg   <= '0;
            act_reg     <= ACT_NOP;
            for (int i = 0; i < ENTRIES; i++) begin
                ins_rank_reg[i] <= '0;
                use_rank_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_POLICY) begin
                    policy_reg <= cfg_data[POLICY_W-1:0];
                end else if (cfg_index == REG_ENTRIES) begin
                    entries_reg <= cfg_data[LIMIT_W-1:0];
                end
            end
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int i = 0; i < ENTRIES; i++) begin
                ins_rank_reg[i] <= ins_rank_next[i];
                use_rank_reg[i] <= use_rank_next[i];
            end
            if (cmd.find_en) begin
                act_reg <= act_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.find_en) begin
            page_reg  <= s_page;
            frame_reg <= s_frame;
            sel_reg   <= sel_new;
        end
        if (cmd.commit_en) begin
            if ((act_reg == ACT_FILL) || (act_reg == ACT_REPLACE)) begin
                page_mem[sel_reg]  <= page_reg;
                frame_mem[sel_reg] <= frame_reg;
            end
            m_hit          <= (act_reg == ACT_HIT);
            m_found_frame  <= (act_reg == ACT_HIT) ? frame_mem[sel_reg] : '0;
            m_evicted      <= (act_reg == ACT_REPLACE);
            m_evicted_page <= (act_reg == ACT_REPLACE) ? page_mem[sel_reg] : '0;
            m_policy_error <= (act_reg == ACT_ERROR);
        end
    end

endmodule

`default_nettype wire
